// ----- rtl/core/jbt_pkg.sv -----
// jbt_pkg: shared types, token codes, character codes and keyword helpers
// for the JSON byte tokenizer. No dependencies.

package jbt_pkg;

   // Default sizes handed to the top level
   localparam int LINE_BITS_DEFAULT   = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int LINE_OUT_BITS       = 16;

   // Token kinds
   localparam logic [3:0] KIND_LBRACE   = 4'd0;
   localparam logic [3:0] KIND_RBRACE   = 4'd1;
   localparam logic [3:0] KIND_LBRACKET = 4'd2;
   localparam logic [3:0] KIND_RBRACKET = 4'd3;
   localparam logic [3:0] KIND_COMMA    = 4'd4;
   localparam logic [3:0] KIND_COLON    = 4'd5;
   localparam logic [3:0] KIND_STRBYTE  = 4'd6;
   localparam logic [3:0] KIND_STREND   = 4'd7;
   localparam logic [3:0] KIND_WORDBYTE = 4'd8;
   localparam logic [3:0] KIND_NUMBER   = 4'd9;
   localparam logic [3:0] KIND_TRUE     = 4'd10;
   localparam logic [3:0] KIND_FALSE    = 4'd11;
   localparam logic [3:0] KIND_NULL     = 4'd12;

   // Characters
   localparam logic [7:0] CHR_NUL      = 8'h00;
   localparam logic [7:0] CHR_NEWLINE  = 8'h0A;
   localparam logic [7:0] CHR_SPACE    = 8'h20;
   localparam logic [7:0] CHR_QUOTE    = 8'h22;
   localparam logic [7:0] CHR_COMMA    = 8'h2C;
   localparam logic [7:0] CHR_COLON    = 8'h3A;
   localparam logic [7:0] CHR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHR_RBRACE   = 8'h7D;

   // Keyword slots: bit 0 true, bit 1 false, bit 2 null
   localparam logic [1:0] KW_TRUE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_NULL  = 2'd2;
   localparam logic [2:0] KW_ALL   = 3'b111;

   // Scanner state, one-hot
   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_STR  = 4'b0010,
      MODE_WORD = 4'b0100,
      MODE_DONE = 4'b1000
   } jbt_mode_type;

   // One queued job: one or two result beats caused by one input byte
   typedef struct packed {
      logic [3:0]               kind0;
      logic [7:0]               value0;
      logic [3:0]               kind1;
      logic                     two;
      logic [LINE_OUT_BITS-1:0] line;
   } jbt_job_type;

   function automatic logic [2:0] kw_len(input logic [1:0] k);
      case (k)
         KW_TRUE:  kw_len = 3'd4;
         KW_FALSE: kw_len = 3'd5;
         KW_NULL:  kw_len = 3'd4;
         default:  kw_len = 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
      logic [39:0] text;
      case (k)
         KW_TRUE:  text = {"true", 8'h00};
         KW_FALSE: text = "false";
         KW_NULL:  text = {"null", 8'h00};
         default:  text = '0;
      endcase
      case (idx)
         3'd0:    kw_char = text[39:32];
         3'd1:    kw_char = text[31:24];
         3'd2:    kw_char = text[23:16];
         3'd3:    kw_char = text[15:8];
         3'd4:    kw_char = text[7:0];
         default: kw_char = 8'h00;
      endcase
   endfunction

   // Drop every keyword that the next word byte rules out
   function automatic logic [2:0] word_cand(input logic [2:0] cand, input logic [2:0] len,
                                            input logic [7:0] b);
      logic [2:0] res;
      res = cand;
      for (int k = 0; k < 3; k++) begin
         if (!(len < kw_len(2'(k)) && kw_char(2'(k), len) == b)) begin
            res[k] = 1'b0;
         end
      end
      word_cand = res;
   endfunction

   function automatic logic [3:0] close_kind(input logic [2:0] cand, input logic [2:0] len);
      logic [3:0] kind;
      kind = KIND_NUMBER;
      if (cand[KW_TRUE] && len == kw_len(KW_TRUE)) kind = KIND_TRUE;
      if (cand[KW_FALSE] && len == kw_len(KW_FALSE)) kind = KIND_FALSE;
      if (cand[KW_NULL] && len == kw_len(KW_NULL)) kind = KIND_NULL;
      close_kind = kind;
   endfunction

endpackage

// ----- rtl/core/jbt_if.sv -----
// jbt_if: valid/ready channel interfaces for the tokenizer's text input and
// token output. Depends on nothing.

interface jbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface jbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [7:0]  value_byte;
   logic [15:0] line_number;
   logic        run_last;

   modport source (output valid, output token_kind, output value_byte,
                   output line_number, output run_last, input ready);
   modport sink (input valid, input token_kind, input value_byte,
                 input line_number, input run_last, output ready);
endinterface

// ----- rtl/core/jbt_front.sv -----
// jbt_front: accepts text bytes, runs the scanner state and turns each byte that causes tokens
// into a job of up to two token beats. Depends on jbt_pkg and jbt_req_if.

module jbt_front import jbt_pkg::*; #(
   parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   jbt_req_if.sink     req_bus,
   input  logic        queue_full,
   output logic        push,
   output jbt_job_type push_job
);

   jbt_mode_type           mode_ff, mode_in;
   logic [2:0]             cand_ff, cand_in;
   logic [2:0]             wlen_ff, wlen_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [LINE_BITS-1:0]   line_inc;
   logic [LINE_OUT_BITS-1:0] line_show;

   logic       accept;
   logic [7:0] b;
   logic       is_term;
   logic       idle_tok, idle_nl, idle_end, idle_quote, idle_space;
   logic [3:0] idle_kind;
   logic [1:0] pcount;
   logic [3:0] pk0, pk1, fk;
   logic [7:0] pv0;
   logic       fin_emit;

   assign req_bus.ready = ~queue_full;
   assign accept        = req_bus.valid & ~queue_full;
   assign b             = req_bus.text_byte;

   assign line_inc = (&line_ff) ? line_ff : line_ff + LINE_BITS'(1);

   if (LINE_BITS > LINE_OUT_BITS) begin : g_line_sat
      assign line_show = (|line_ff[LINE_BITS-1:LINE_OUT_BITS]) ? '1
                                                                : line_ff[LINE_OUT_BITS-1:0];
   end else begin : g_line_ext
      assign line_show = LINE_OUT_BITS'(line_ff);
   end

   assign is_term = (b == CHR_NUL) || (b == CHR_COMMA) || (b == CHR_SPACE) ||
                    (b == CHR_NEWLINE) || (b == CHR_RBRACE) || (b == CHR_RBRACKET);

   // Classify the byte as seen between tokens
   always_comb begin
      idle_tok   = 1'b1;
      idle_kind  = KIND_LBRACE;
      idle_nl    = 1'b0;
      idle_end   = 1'b0;
      idle_quote = 1'b0;
      idle_space = 1'b0;
      case (b)
         CHR_LBRACE:   idle_kind = KIND_LBRACE;
         CHR_RBRACE:   idle_kind = KIND_RBRACE;
         CHR_LBRACKET: idle_kind = KIND_LBRACKET;
         CHR_RBRACKET: idle_kind = KIND_RBRACKET;
         CHR_COMMA:    idle_kind = KIND_COMMA;
         CHR_COLON:    idle_kind = KIND_COLON;
         CHR_NUL: begin
            idle_tok = 1'b0;
            idle_end = 1'b1;
         end
         CHR_NEWLINE: begin
            idle_tok = 1'b0;
            idle_nl  = 1'b1;
         end
         CHR_SPACE: begin
            idle_tok   = 1'b0;
            idle_space = 1'b1;
         end
         CHR_QUOTE: begin
            idle_tok   = 1'b0;
            idle_quote = 1'b1;
         end
         default: idle_tok = 1'b0;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      cand_in  = cand_ff;
      wlen_in  = wlen_ff;
      line_in  = line_ff;
      pcount   = 2'd0;
      pk0      = KIND_NUMBER;
      pv0      = 8'h00;
      pk1      = KIND_NUMBER;
      fk       = KIND_STREND;
      fin_emit = 1'b0;

      case (mode_ff)
         MODE_STR: begin
            pcount = 2'd1;
            if (b == CHR_NUL) begin
               pk0     = KIND_STREND;
               mode_in = MODE_DONE;
            end else if (b == CHR_QUOTE) begin
               pk0     = KIND_STREND;
               mode_in = MODE_IDLE;
            end else begin
               pk0 = KIND_STRBYTE;
               pv0 = b;
            end
         end
         MODE_WORD: begin
            if (is_term) begin
               // close the word, then treat the byte as between tokens
               pk0     = close_kind(cand_ff, wlen_ff);
               mode_in = idle_end ? MODE_DONE : MODE_IDLE;
               if (idle_tok) begin
                  pcount = 2'd2;
                  pk1    = idle_kind;
               end else begin
                  pcount = 2'd1;
               end
               if (idle_nl) line_in = line_inc;
            end else begin
               pcount  = 2'd1;
               pk0     = KIND_WORDBYTE;
               pv0     = b;
               cand_in = word_cand(cand_ff, wlen_ff, b);
               wlen_in = (wlen_ff == 3'd7) ? wlen_ff : wlen_ff + 3'd1;
            end
         end
         MODE_IDLE: begin
            if (idle_end) begin
               mode_in = MODE_DONE;
            end else if (idle_tok) begin
               pcount = 2'd1;
               pk0    = idle_kind;
            end else if (idle_nl) begin
               line_in = line_inc;
            end else if (idle_quote) begin
               mode_in = MODE_STR;
            end else if (!idle_space) begin
               // first byte of a word
               pcount  = 2'd1;
               pk0     = KIND_WORDBYTE;
               pv0     = b;
               cand_in = word_cand(KW_ALL, 3'd0, b);
               wlen_in = 3'd1;
               mode_in = MODE_WORD;
            end
         end
         default: ;
      endcase

      // Last byte of the file: close what is open, then back to reset values
      if (req_bus.final_byte) begin
         if (mode_in == MODE_WORD) begin
            fin_emit = 1'b1;
            fk       = close_kind(cand_in, wlen_in);
         end else if (mode_in == MODE_STR) begin
            fin_emit = 1'b1;
            fk       = KIND_STREND;
         end
         mode_in = MODE_IDLE;
         cand_in = KW_ALL;
         wlen_in = 3'd0;
         line_in = LINE_BITS'(1);
      end
   end

   // Pack the beats of this byte into one job
   always_comb begin
      push_job.line = line_show;
      if (pcount == 2'd0) begin
         push_job.kind0  = fk;
         push_job.value0 = 8'h00;
         push_job.kind1  = fk;
         push_job.two    = 1'b0;
      end else begin
         push_job.kind0  = pk0;
         push_job.value0 = pv0;
         if (pcount == 2'd2) begin
            push_job.kind1 = pk1;
            push_job.two   = 1'b1;
         end else begin
            push_job.kind1 = fk;
            push_job.two   = fin_emit;
         end
      end
   end

   assign push = accept & ((pcount != 2'd0) | fin_emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         cand_ff <= KW_ALL;
         wlen_ff <= 3'd0;
         line_ff <= LINE_BITS'(1);
      end else if (accept) begin
         mode_ff <= mode_in;
         cand_ff <= cand_in;
         wlen_ff <= wlen_in;
         line_ff <= line_in;
      end
   end

endmodule

// ----- rtl/core/jbt_queue.sv -----
// jbt_queue: small job FIFO between the scanner front and the beat back end.
// Depends on jbt_pkg.

module jbt_queue import jbt_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  jbt_job_type push_job,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output jbt_job_type head_job
);

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   jbt_job_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign full       = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/core/jbt_back.sv -----
// jbt_back: output register that plays each queued job out as one or two
// token beats. Depends on jbt_pkg and jbt_rsp_if.

module jbt_back import jbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  jbt_job_type head_job,
   output logic        pop,
   jbt_rsp_if.source   rsp_bus
);

   logic        valid_ff, valid_in;
   logic        phase_ff, phase_in;
   jbt_job_type job_ff, job_in;
   logic        last_beat;
   logic        taken;

   assign last_beat = phase_ff | ~job_ff.two;
   assign taken     = valid_ff & rsp_bus.ready;
   assign pop       = head_valid & (~valid_ff | (taken & last_beat));

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.token_kind  = phase_ff ? job_ff.kind1 : job_ff.kind0;
   assign rsp_bus.value_byte  = phase_ff ? 8'h00 : job_ff.value0;
   assign rsp_bus.line_number = job_ff.line;
   assign rsp_bus.run_last    = last_beat;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      job_in   = job_ff;
      if (pop) begin
         valid_in = 1'b1;
         phase_in = 1'b0;
         job_in   = head_job;
      end else if (taken) begin
         if (last_beat) begin
            valid_in = 1'b0;
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

// ----- rtl/core/json_byte_tokenizer.sv -----
// json_byte_tokenizer: top level of the JSON byte tokenizer.
// Throughput: one byte per cycle while the job queue is not full. Each job passes from
// the queue to the output register; a byte that causes two tokens uses two output beats.
// The job queue (QUEUE_DEPTH entries) absorbs bursts of two-token bytes and output stalls.
// Reset (synchronous, active high): scanner idle, line count one, queue and output empty.
// Depends on jbt_pkg, jbt_if, jbt_front, jbt_queue and jbt_back.

module json_byte_tokenizer import jbt_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEFAULT,   // 8 to 32
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT  // 2 or more
) (
   input logic       clock,
   input logic       reset,
   jbt_req_if.sink   req_bus,
   jbt_rsp_if.source rsp_bus
);

   // Front to queue
   logic        push;
   jbt_job_type push_job;
   logic        queue_full;

   // Queue to back
   logic        pop;
   logic        head_valid;
   jbt_job_type head_job;

   // Front: hold the scanner state, classify each byte, and build one job for
   // every byte that produces tokens. It stalls only when the queue is full.
   jbt_front #(
      .LINE_BITS (LINE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Queue: decouple the byte side from the token side.
   jbt_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Back: advance through each job one beat at a time and flag the last beat
   // of every byte with run_last.
   jbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ----- test/testbench.sv -----
// testbench: self-checking bench for json_byte_tokenizer, driving text bytes and checking
// every token beat against an in-bench scanner model.
// Depends on jbt_pkg, the jbt_req_if / jbt_rsp_if interfaces and the json_byte_tokenizer RTL.
`timescale 1ns / 100ps

module testbench;
   import jbt_pkg::*;

   localparam int LINE_BITS  = LINE_BITS_DEFAULT;
   localparam int IDLE_LIMIT = 2000;  // cycles with no beat on either side
   localparam int LONG_HOLD  = 250;   // one long output stall, in cycles
   localparam int TAIL       = 16;    // quiet cycles after the last token
   localparam int RAND_ITEMS = 800;

   // One text beat as queued for the driver; pause marks a wait for the output to drain
   typedef struct packed {
      logic [7:0] text;
      logic       fin;
      logic       pause;
   } text_beat_type;

   // One token beat as the block should present it
   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  value;
      logic [15:0] line;
      logic        last;
   } token_beat_type;

   logic clock;
   logic reset;

   jbt_req_if req_bus ();
   jbt_rsp_if rsp_bus ();

   json_byte_tokenizer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   text_beat_type  text_backlog[$];   // bytes still to be offered
   token_beat_type tokens_due[$];     // tokens predicted and not yet seen
   token_beat_type byte_tokens[$];    // tokens caused by the byte being scanned

   // Scanner model state
   jbt_mode_type           scan_mode;
   logic [LINE_BITS-1:0]   line_cnt;
   logic [2:0]             word_len;
   logic [39:0]            word_tail;  // last five bytes of the current word

   int items_queued = 0;
   int bytes_in = 0;
   int toks_out = 0;
   int docs = 0;
   int mismatches = 0;
   int burst_left;
   int gap_left;
   int stall_tick;
   int stall_mode;
   int hold_left;
   bit long_hold_done = 1'b0;
   int idle_cycles = 0;

   // ---------------------------------------------------------------------------------------
   // Scanner model
   // ---------------------------------------------------------------------------------------

   // Return the scanner to its power-up state
   function automatic void clear_scanner();
      scan_mode = MODE_IDLE;
      line_cnt  = LINE_BITS'(1);
      word_len  = 3'd0;
      word_tail = '0;
   endfunction

   // Bytes that close an open word
   function automatic bit is_word_end(input logic [7:0] b);
      return b == CHR_NUL || b == CHR_COMMA || b == CHR_SPACE || b == CHR_NEWLINE ||
             b == CHR_RBRACE || b == CHR_RBRACKET;
   endfunction

   // Tag a token with the current line, clamped to the 16-bit output field
   function automatic void put_token(input logic [3:0] kind, input logic [7:0] value);
      token_beat_type t;
      t.kind  = kind;
      t.value = value;
      t.line  = (line_cnt > 16'hFFFF) ? 16'hFFFF : 16'(line_cnt);
      t.last  = 1'b0;
      byte_tokens.insert(byte_tokens.size(), t);
   endfunction

   function automatic void add_word_byte(input logic [7:0] b);
      if (word_len < 3'd7) word_len = word_len + 3'd1;
      word_tail = {word_tail[31:0], b};
      put_token(KIND_WORDBYTE, b);
   endfunction

   // A word is a keyword only on an exact match, length included
   function automatic void close_word();
      logic [3:0] kind;
      kind = KIND_NUMBER;
      if (word_len == 3'd4 && word_tail[31:0] == "true") kind = KIND_TRUE;
      else if (word_len == 3'd4 && word_tail[31:0] == "null") kind = KIND_NULL;
      else if (word_len == 3'd5 && word_tail == "false") kind = KIND_FALSE;
      put_token(kind, 8'h00);
      scan_mode = MODE_IDLE;
   endfunction

   // Handle a byte that arrives between tokens
   function automatic void idle_byte(input logic [7:0] b);
      case (b)
         CHR_NUL:      scan_mode = MODE_DONE;
         CHR_LBRACE:   put_token(KIND_LBRACE, 8'h00);
         CHR_RBRACE:   put_token(KIND_RBRACE, 8'h00);
         CHR_LBRACKET: put_token(KIND_LBRACKET, 8'h00);
         CHR_RBRACKET: put_token(KIND_RBRACKET, 8'h00);
         CHR_COMMA:    put_token(KIND_COMMA, 8'h00);
         CHR_COLON:    put_token(KIND_COLON, 8'h00);
         CHR_NEWLINE:  if (line_cnt != '1) line_cnt = line_cnt + LINE_BITS'(1);
         CHR_SPACE:    ;
         CHR_QUOTE:    scan_mode = MODE_STR;
         default: begin
            word_len  = 3'd0;
            word_tail = '0;
            scan_mode = MODE_WORD;
            add_word_byte(b);
         end
      endcase
   endfunction

   // Scan one accepted byte and queue the tokens it causes
   function automatic void tokenize_byte(input logic [7:0] b, input logic fin);
      byte_tokens.delete();
      case (scan_mode)
         MODE_STR: begin
            if (b == CHR_NUL) begin
               put_token(KIND_STREND, 8'h00);
               scan_mode = MODE_DONE;
            end else if (b == CHR_QUOTE) begin
               put_token(KIND_STREND, 8'h00);
               scan_mode = MODE_IDLE;
            end else begin
               put_token(KIND_STRBYTE, b);
            end
         end
         MODE_WORD: begin
            if (is_word_end(b)) begin
               close_word();
               idle_byte(b);
            end else begin
               add_word_byte(b);
            end
         end
         MODE_IDLE: idle_byte(b);
         default: ;  // text ended: ignore until the final byte
      endcase
      if (fin) begin
         if (scan_mode == MODE_WORD) close_word();
         else if (scan_mode == MODE_STR) put_token(KIND_STREND, 8'h00);
         clear_scanner();
      end
      if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].last = 1'b1;
      foreach (byte_tokens[i]) tokens_due.insert(tokens_due.size(), byte_tokens[i]);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   task automatic push_byte(input logic [7:0] b, input logic fin);
      text_beat_type beat;
      beat.text  = b;
      beat.fin   = fin;
      beat.pause = 1'b0;
      text_backlog.insert(text_backlog.size(), beat);
      items_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
   endtask

   // Hold the sender until every predicted token has come out
   task automatic push_pause();
      text_beat_type beat;
      beat.text  = 8'h00;
      beat.fin   = 1'b0;
      beat.pause = 1'b1;
      text_backlog.insert(text_backlog.size(), beat);
   endtask

   // ---------------------------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Driver: offer backlog bytes in bursts, hold a byte until it is taken
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      text_beat_type head;
      logic          stuck;
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.text_byte  <= 8'h00;
         req_bus.final_byte <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
         clear_scanner();
      end else begin
         stuck = req_bus.valid && !req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            tokenize_byte(req_bus.text_byte, req_bus.final_byte);
            head = text_backlog.pop_front();
            bytes_in++;
         end
         // A byte on offer stays put until the block takes it
         if (!stuck) begin
            if (text_backlog.size() > 0 && text_backlog[0].pause && tokens_due.size() == 0)
               head = text_backlog.pop_front();
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (text_backlog.size() > 0 && !text_backlog[0].pause) begin
               head = text_backlog[0];
               req_bus.valid      <= 1'b1;
               req_bus.text_byte  <= head.text;
               req_bus.final_byte <= head.fin;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  // Pick the next burst; a quarter of them follow with no gap at all
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: check token beats and drive the stall pattern of the receiver
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      token_beat_type seen;
      token_beat_type want;
      logic           rdy;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_tick = 0;
         stall_mode = 0;
         hold_left  = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.token_kind, rsp_bus.value_byte, rsp_bus.line_number,
                    rsp_bus.run_last};
            toks_out++;
            if (tokens_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected token beat: kind %0d value %02h line %0d last %0b",
                           seen.kind, seen.value, seen.line, seen.last);
            end else begin
               want = tokens_due.pop_front();
               if (seen.kind !== want.kind || seen.value !== want.value ||
                   seen.line !== want.line || seen.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"token mismatch at beat %0d: expected kind %0d value %02h ",
                               "line %0d last %0b, got kind %0d value %02h line %0d last %0b"},
                              toks_out, want.kind, want.value, want.line, want.last,
                              seen.kind, seen.value, seen.line, seen.last);
               end
            end
         end

         // Step the tick counter; it sets when a new random stall pattern is picked
         stall_tick++;
         if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);

         if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
         end else if (!long_hold_done && toks_out >= 300) begin
            // Drop ready for a long stretch so the job queue fills and input backs up
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            rdy            = 1'b0;
         end else begin
            case (stall_mode)
               0:       rdy = 1'b1;
               1:       rdy = 1'($urandom_range(0, 1));
               2:       rdy = ($urandom_range(0, 3) == 0);
               default: rdy = (stall_tick % 5) != 0;
            endcase
         end
         rsp_bus.ready <= rdy;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog: end the run when nothing moves on either side for too long
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d tokens still due",
                     IDLE_LIMIT, tokens_due.size());
            $display("** json_byte_tokenizer: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence: build the backlog, reset, wait for drain, report
   // ---------------------------------------------------------------------------------------

   initial begin
      int         n_tok;
      int         k;
      int         rand_start;
      logic [7:0] b;
      string      w;
      string      num_chars;

      num_chars = "0123456789-+.eE";
      reset     = 1'b1;

      // Directed: every structural token, a string holding a newline and byte FF,
      // null closed by a bracket, true closed by a space, false closed by a comma
      push_text("{\"\n");
      push_byte(8'hFF, 1'b0);
      push_text("\":[null]}");
      push_text("true \nfalse,");
      push_byte("x", 1'b1);            // final byte closes an open word
      push_text("1");
      push_byte(CHR_NUL, 1'b0);        // byte zero closes the word and ends the text
      push_byte(CHR_LBRACE, 1'b0);     // ignored after the text has ended
      push_byte(CHR_LBRACE, 1'b1);     // ignored too, final brings back reset state
      push_byte(CHR_QUOTE, 1'b0);
      push_byte("a", 1'b1);            // final byte closes an open string
      push_pause();
      docs = 3;

      // Random documents: mostly well-formed token streams, some raw noise
      rand_start = items_queued;
      while (items_queued - rand_start < RAND_ITEMS) begin
         docs++;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 20))
               push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end else begin
            n_tok = $urandom_range(1, 12);
            repeat (n_tok) begin
               case ($urandom_range(0, 9))
                  0, 1: begin
                     case ($urandom_range(0, 5))
                        0:       b = CHR_LBRACE;
                        1:       b = CHR_RBRACE;
                        2:       b = CHR_LBRACKET;
                        3:       b = CHR_RBRACKET;
                        4:       b = CHR_COMMA;
                        default: b = CHR_COLON;
                     endcase
                     push_byte(b, 1'b0);
                  end
                  2, 3: begin
                     // String with arbitrary content, sometimes left open
                     push_byte(CHR_QUOTE, 1'b0);
                     repeat ($urandom_range(0, 6)) begin
                        b = 8'($urandom_range(1, 255));
                        if (b == CHR_QUOTE) b = 8'h5C;
                        push_byte(b, 1'b0);
                     end
                     if ($urandom_range(0, 7) != 0) push_byte(CHR_QUOTE, 1'b0);
                  end
                  4, 5, 6: begin
                     case ($urandom_range(0, 9))
                        0: w = "true";
                        1: w = "false";
                        2: w = "null";
                        3: w = "tru";
                        4: w = "nul";
                        5: w = "falsey";
                        6: w = "nulll";
                        7: w = "truE";
                        8: begin
                           w = "";
                           repeat ($urandom_range(1, 6)) begin
                              k = $urandom_range(0, num_chars.len() - 1);
                              w = {w, num_chars.substr(k, k)};
                           end
                        end
                        default: begin
                           // Odd word bytes: quotes, colons, high bytes and the like
                           w = "z";
                           repeat ($urandom_range(0, 4)) begin
                              b = 8'($urandom_range(1, 255));
                              if (is_word_end(b)) b = "k";
                              w = $sformatf("%s%c", w, b);
                           end
                        end
                     endcase
                     push_text(w);
                     case ($urandom_range(0, 7))
                        0, 7:    push_byte(CHR_COMMA, 1'b0);
                        1:       push_byte(CHR_SPACE, 1'b0);
                        2:       push_byte(CHR_NEWLINE, 1'b0);
                        3:       push_byte(CHR_RBRACE, 1'b0);
                        4:       push_byte(CHR_RBRACKET, 1'b0);
                        5:       ;  // run into the next token
                        default: push_byte(CHR_NUL, 1'b0);
                     endcase
                  end
                  7, 8:    push_byte(($urandom_range(0, 1) == 0) ? CHR_SPACE : CHR_NEWLINE, 1'b0);
                  default: push_byte(CHR_COLON, 1'b0);
               endcase
            end
            if ($urandom_range(0, 5) == 0) begin
               push_byte(CHR_NUL, 1'b0);
               repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
         end
         // Close the document on its last byte
         text_backlog[text_backlog.size()-1].fin = 1'b1;
         if (docs % 25 == 0) push_pause();
      end

      // Hold reset, then release it for good
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait for the backlog to go out and every predicted token to arrive
      while (text_backlog.size() > 0 || req_bus.valid || tokens_due.size() > 0)
         @(negedge clock);
      repeat (TAIL) @(posedge clock);

      $display("covered %0d text bytes in %0d documents, %0d token beats checked,",
               bytes_in, docs, toks_out);
      $display("string/word edge cases, drain pauses and a %0d-cycle output hold",
               LONG_HOLD);
      if (mismatches == 0) begin
         $display("** json_byte_tokenizer: PASSED **");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("** json_byte_tokenizer: FAILED **");
      end
      $finish;
   end

endmodule
